@@ hw/rtl/superadditive_rounding_function_assert.svh @@
// Assertion macros for the superadditive rounding function checker.
`ifndef SUPERADDITIVE_ROUNDING_FUNCTION_ASSERT_SVH
`define SUPERADDITIVE_ROUNDING_FUNCTION_ASSERT_SVH

// same-cycle implication
`define SRF_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("srf assertion failed");

// next-cycle implication
`define SRF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("srf assertion failed");

`endif

@@ hw/rtl/srf_pkg.sv @@
// Shared constants and register codes of the superadditive rounding function.
package srf_pkg;

  localparam int unsigned CoeffWidthDef = 32;
  localparam int unsigned ScaleMaxDef   = 64;
  localparam int unsigned DataWidth     = 31;
  localparam int unsigned MsWidth       = 7;
  localparam int unsigned OutWidth      = 39;
  localparam int unsigned CfgIdxWidth   = 2;
  localparam int unsigned LodiCap       = 2;

  localparam logic [DataWidth-1:0] RemReset      = '0;
  localparam logic [DataWidth-1:0] DivReset      = DataWidth'(1);
  localparam logic [MsWidth-1:0]   MaxScaleReset = MsWidth'(60);

  typedef enum logic [CfgIdxWidth-1:0] {
    RegLodi     = 2'd0,
    RegRem      = 2'd1,
    RegDiv      = 2'd2,
    RegMaxScale = 2'd3
  } cfg_reg_e;

endpackage

@@ hw/rtl/superadditive_rounding_function.sv @@
// Top level of the superadditive rounding function pipeline.
// Throughput: one coefficient per cycle while in_stall_o is low; the two bit-per-stage dividers set the depth.
// After reset and after each register write, the scale derivation holds in_stall_o
// high until it returns to idle; config writes are always taken.
// Reset is asynchronous, active low, clears all valid bits and returns the config registers to their reset values.
module superadditive_rounding_function #(
  parameter int unsigned COEFF_WIDTH = srf_pkg::CoeffWidthDef,
  parameter int unsigned SCALE_MAX   = srf_pkg::ScaleMaxDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [srf_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [srf_pkg::DataWidth-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [COEFF_WIDTH-1:0]       coefficient_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [srf_pkg::OutWidth-1:0] rounded_value_o,
  output logic                                config_error_o
);
  import srf_pkg::*;

  localparam int unsigned TW   = $clog2(SCALE_MAX+1);
  localparam int unsigned DW   = DataWidth;
  localparam int unsigned PW   = COEFF_WIDTH + TW;
  localparam int unsigned MW   = PW - 1;
  localparam int unsigned EW   = DW + 1;
  localparam int unsigned NUMW = DW + TW;
  localparam int unsigned NCW  = NUMW + 1;
  localparam int unsigned OW   = OutWidth;

  logic          busy, err;
  logic [DW-1:0] div_w, r_w, size_w;
  logic [TW-1:0] t_w, s_w;
  logic          en, acc;

  srf_cfg #(.SCALE_MAX(SCALE_MAX)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .divisor_o   (div_w),
    .t_o         (t_w),
    .s_o         (s_w),
    .r_o         (r_w),
    .size_o      (size_w),
    .err_o       (err)
  );

  assign cfg_ready_o = 1'b1;
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = busy || !en;
  assign acc         = in_valid_i && !in_stall_o;

  logic                          va_q, vb_q, vc_q;
  logic signed [COEFF_WIDTH-1:0] c_q;
  logic signed [PW-1:0]          p_d, p_q;
  logic                          neg_q;
  logic [MW-1:0]                 mag_q;

  assign p_d = c_q * $signed({1'b0, t_w});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      va_q <= acc;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q   <= coefficient_i;
      p_q   <= p_d;
      neg_q <= p_q[PW-1];
      mag_q <= p_q[PW-1] ? MW'(-p_q) : MW'(p_q);
    end
  end

  logic          v1;
  logic [MW-1:0] qa;
  logic [DW-1:0] ra;
  logic          neg1;

  srf_div #(.NW(MW), .DW(DW), .SW(1)) u_div_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vc_q),
    .rem_i  ('0),
    .num_i  (mag_q),
    .sb_i   (neg_q),
    .den_i  (div_w),
    .vld_o  (v1),
    .quo_o  (qa),
    .rem_o  (ra),
    .sb_o   (neg1)
  );

  logic                 vd_q, ve_q, vf_q, vg_q;
  logic signed [PW-1:0] q_d, qd_q, qe_q, qf_q, qg_q;
  logic [DW-1:0]        m_d, m_q;
  logic signed [EW-1:0] e_d, e_q, ef_q, eg_q;
  logic                 epos;
  logic [NUMW-1:0]      num_d, num_q;
  logic [NCW-1:0]       numc_d, numc_q;

  always_comb begin
    if (!neg1) begin
      q_d = $signed({1'b0, qa});
      m_d = ra;
    end else if (ra == '0) begin
      q_d = -$signed({1'b0, qa});
      m_d = '0;
    end else begin
      q_d = -$signed({1'b0, qa}) - PW'(1);
      m_d = div_w - ra;
    end
  end

  assign e_d    = $signed({1'b0, m_q}) - $signed({1'b0, r_w});
  assign epos   = !e_q[EW-1] && (e_q != '0);
  assign num_d  = epos ? (NUMW'(e_q[DW-1:0]) * NUMW'(s_w - TW'(1))) : '0;
  assign numc_d = NCW'(num_q) + NCW'(size_w) - NCW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
    end else if (en) begin
      vd_q <= v1;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qd_q   <= q_d;
      m_q    <= m_d;
      qe_q   <= qd_q;
      e_q    <= e_d;
      qf_q   <= qe_q;
      ef_q   <= e_q;
      num_q  <= num_d;
      qg_q   <= qf_q;
      eg_q   <= ef_q;
      numc_q <= numc_d;
    end
  end

  logic                 v2;
  logic [TW-1:0]        bucket;
  logic [DW-1:0]        rem2;
  logic [PW+EW-1:0]     sb2;
  logic signed [PW-1:0] q2;
  logic signed [EW-1:0] e2;

  srf_div #(.NW(TW), .DW(DW), .SW(PW+EW)) u_div_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vg_q),
    .rem_i  (DW'(numc_q >> TW)),
    .num_i  (numc_q[TW-1:0]),
    .sb_i   ({qg_q, eg_q}),
    .den_i  (size_w),
    .vld_o  (v2),
    .quo_o  (bucket),
    .rem_o  (rem2),
    .sb_o   (sb2)
  );

  assign q2 = $signed(sb2[PW+EW-1:EW]);
  assign e2 = $signed(sb2[EW-1:0]);

  logic                 vh_q, vo_q;
  logic [TW-1:0]        mult;
  logic signed [OW-1:0] add_d, add_q, prod_d, prod_q;
  logic signed [OW-1:0] out_q;
  logic                 err_q;
  logic                 e2pos;

  assign e2pos = !e2[EW-1] && (e2 != '0);

  always_comb begin
    if (s_w == TW'(1)) begin
      mult  = TW'(1);
      add_d = '0;
    end else if (size_w <= DW'(s_w)) begin
      mult  = size_w[TW-1:0];
      add_d = e2pos ? OW'($signed({1'b0, e2[DW-1:0]})) : '0;
    end else begin
      mult  = s_w;
      add_d = OW'($signed({1'b0, bucket}));
    end
  end

  assign prod_d = OW'(q2) * OW'($signed({1'b0, mult}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      vh_q <= v2;
      vo_q <= vh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      add_q  <= add_d;
      out_q  <= err ? '0 : (prod_q + add_q);
      err_q  <= err;
    end
  end

  assign out_valid_o     = vo_q;
  assign rounded_value_o = out_q;
  assign config_error_o  = err_q;

endmodule

@@ hw/rtl/srf_cfg.sv @@
// Configuration registers and sequential derivation of scale, scaling and size.
module srf_cfg #(
  parameter int unsigned SCALE_MAX = srf_pkg::ScaleMaxDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [srf_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [srf_pkg::DataWidth-1:0]         cfg_data_i,
  output logic                                  busy_o,
  output logic [srf_pkg::DataWidth-1:0]         divisor_o,
  output logic [$clog2(SCALE_MAX+1)-1:0]        t_o,
  output logic [$clog2(SCALE_MAX+1)-1:0]        s_o,
  output logic [srf_pkg::DataWidth-1:0]         r_o,
  output logic [srf_pkg::DataWidth-1:0]         size_o,
  output logic                                  err_o
);
  import srf_pkg::*;

  localparam int unsigned TW = $clog2(SCALE_MAX+1);
  localparam int unsigned DW = DataWidth;
  localparam int unsigned AW = DW + TW;

  localparam logic [2:0] StInit = 3'd0;
  localparam logic [2:0] StT    = 3'd1;
  localparam logic [2:0] StS    = 3'd2;
  localparam logic [2:0] StFin  = 3'd3;
  localparam logic [2:0] StSize = 3'd4;
  localparam logic [2:0] StIdle = 3'd5;

  logic               lodi_q;
  logic [DW-1:0]      rem_q, div_q;
  logic [MsWidth-1:0] ms_raw_q;
  logic [TW-1:0]      ms_c;
  logic [DW-1:0]      half;
  logic [AW-1:0]      rt_prod;

  logic [2:0]    st_q, st_d;
  logic [TW-1:0] k_q, k_d;
  logic [AW-1:0] acc_q, acc_d;
  logic [TW-1:0] s_q, s_d;
  logic [TW:0]   sum_q, sum_d;
  logic [DW-1:0] r_q, r_d;
  logic [DW-1:0] size_q, size_d;
  logic          err_q, err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lodi_q   <= 1'b0;
      rem_q    <= RemReset;
      div_q    <= DivReset;
      ms_raw_q <= MaxScaleReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegLodi:     lodi_q   <= cfg_data_i[0];
        RegRem:      rem_q    <= cfg_data_i;
        RegDiv:      div_q    <= cfg_data_i;
        RegMaxScale: ms_raw_q <= cfg_data_i[MsWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ms_raw_q == '0) begin
      ms_c = TW'(1);
    end else if (32'(ms_raw_q) > 32'(SCALE_MAX)) begin
      ms_c = TW'(SCALE_MAX);
    end else begin
      ms_c = TW'(ms_raw_q);
    end
  end

  assign half    = div_q >> 1;
  assign rt_prod = AW'(rem_q) * AW'(k_q);

  always_comb begin
    st_d   = st_q;
    k_d    = k_q;
    acc_d  = acc_q;
    s_d    = s_q;
    sum_d  = sum_q;
    r_d    = r_q;
    size_d = size_q;
    err_d  = err_q;
    case (st_q)
      StInit: begin
        k_d   = (rem_q == '0) ? ms_c : TW'(1);
        acc_d = AW'(rem_q);
        st_d  = StT;
      end
      StT: begin
        if (rem_q != '0 && k_q < ms_c && acc_q < AW'(half)) begin
          k_d   = k_q + TW'(1);
          acc_d = acc_q + AW'(rem_q);
        end else begin
          s_d   = '0;
          sum_d = {1'b0, k_q};
          st_d  = StS;
        end
      end
      StS: begin
        if (sum_q <= {1'b0, ms_c}) begin
          s_d   = s_q + TW'(1);
          sum_d = sum_q + {1'b0, k_q};
        end else begin
          st_d = StFin;
        end
      end
      StFin: begin
        r_d = rt_prod[DW-1:0];
        if (lodi_q && 32'(s_q) > 32'(LodiCap)) begin
          s_d = TW'(LodiCap);
        end
        err_d = (rem_q >= div_q);
        st_d  = StSize;
      end
      StSize: begin
        size_d = div_q - r_q;
        st_d   = StIdle;
      end
      StIdle: ;
      default: st_d = StIdle;
    endcase
    if (cfg_valid_i) begin
      st_d = StInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StInit;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    acc_q  <= acc_d;
    s_q    <= s_d;
    sum_q  <= sum_d;
    r_q    <= r_d;
    size_q <= size_d;
    err_q  <= err_d;
  end

  assign busy_o    = (st_q != StIdle);
  assign divisor_o = div_q;
  assign t_o       = k_q;
  assign s_o       = s_q;
  assign r_o       = r_q;
  assign size_o    = size_q;
  assign err_o     = err_q;

endmodule

@@ hw/rtl/srf_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module srf_div #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 8,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [SW-1:0] sb_i,
  input  logic [DW-1:0] den_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [SW-1:0] sb_o
);

  logic          vld_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] w_q   [NW];
  logic [SW-1:0] sb_q  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          vin;
    logic [DW-1:0] rin;
    logic [NW-1:0] win;
    logic [SW-1:0] sin;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign vin = vld_i;
      assign rin = rem_i;
      assign win = num_i;
      assign sin = sb_i;
    end else begin : g_next
      assign vin = vld_q[k-1];
      assign rin = rem_q[k-1];
      assign win = w_q[k-1];
      assign sin = sb_q[k-1];
    end

    assign trial = {rin, win[NW-1]};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
        w_q[k]   <= {win[NW-2:0], ge};
        sb_q[k]  <= sin;
      end
    end
  end

  assign vld_o = vld_q[NW-1];
  assign quo_o = w_q[NW-1];
  assign rem_o = rem_q[NW-1];
  assign sb_o  = sb_q[NW-1];

endmodule

@@ hw/rtl/srf_checker.sv @@
// Port-level checker for the superadditive rounding function and its bind.
`include "superadditive_rounding_function_assert.svh"

module srf_checker #(
  parameter int unsigned COEFF_WIDTH = srf_pkg::CoeffWidthDef
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic [srf_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input logic [srf_pkg::DataWidth-1:0]       cfg_data_i,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic signed [COEFF_WIDTH-1:0]       coefficient_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [srf_pkg::OutWidth-1:0] rounded_value_o,
  input logic                                config_error_o
);
  import srf_pkg::*;

  `SRF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `SRF_ASSERT_NOW(a_err_zero, out_valid_o && config_error_o, rounded_value_o == '0)
  `SRF_ASSERT_NEXT(a_cfg_stall, cfg_valid_i && cfg_ready_o, in_stall_o)
  `SRF_ASSERT_NOW(a_back_press, out_valid_o && out_stall_i, in_stall_o)

endmodule

bind superadditive_rounding_function srf_checker #(.COEFF_WIDTH(COEFF_WIDTH)) u_srf_checker (.*);

@@ test/tb_top.sv @@
// Self-checking testbench for the superadditive rounding function pipeline.
module tb_top;
  import srf_pkg::*;

  typedef struct packed {
    logic signed [OutWidth-1:0] value;
    logic                       err;
  } rounding_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CfgIdxWidth-1:0]      cfg_index_i = '0;
  logic [DataWidth-1:0]        cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic signed [31:0]          coefficient_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [OutWidth-1:0]  rounded_value_o;
  logic                        config_error_o;

  logic                 lodi_q = 1'b0;
  logic [DataWidth-1:0] rem_q = RemReset;
  logic [DataWidth-1:0] div_q = DivReset;
  logic [MsWidth-1:0]   max_scale_q = MaxScaleReset;

  logic signed [31:0] coeff_queue[$];
  rounding_t          rounding_queue[$];
  logic signed [31:0] extreme_coeffs [10];
  int                 mismatches = 0;
  int                 transfers_in = 0;
  int                 transfers_out = 0;
  int                 error_results = 0;
  int                 phases_run = 0;
  bit                 burst = 1'b0;
  bit                 hold_kick = 1'b0;
  int                 hold_left;
  int                 tx_gap;
  int                 rx_gap;

  superadditive_rounding_function u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic rounding_t predict_rounding(logic signed [31:0] coeff);
    longint d, rem, ms, t, r, s, sz, q, m, e, v, c, half, need;
    rounding_t res;
    res = '0;
    if (rem_q >= div_q) begin
      res.err = 1'b1;
      return res;
    end
    d = longint'(div_q);
    rem = longint'(rem_q);
    ms = longint'(max_scale_q);
    c = longint'(coeff);
    if (ms < 1) ms = 1;
    if (ms > ScaleMaxDef) ms = ScaleMaxDef;
    if (rem == 0) begin
      t = ms;
    end else begin
      half = d / 2;
      need = (half + rem - 1) / rem;
      t = (need < ms) ? need : ms;
      if (t < 1) t = 1;
    end
    r = rem * t;
    s = ms / t;
    if (lodi_q && s > LodiCap) s = LodiCap;
    if (s < 1) s = 1;
    sz = d - r;
    if (sz < 1) sz = 1;
    q = floor_div(t * c, d);
    if (s == 1) begin
      v = q;
    end else begin
      m = t * c - q * d;
      e = m - r;
      if (sz <= s) v = sz * q + ((e > 0) ? e : 0);
      else v = s * q + ((e > 0) ? (e * (s - 1) + sz - 1) / sz : 0);
    end
    res.value = v[OutWidth-1:0];
    return res;
  endfunction

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        rounding_queue = {rounding_queue, predict_rounding(coefficient_i)};
        transfers_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (coeff_queue.size() > 0) begin
          coefficient_i <= coeff_queue.pop_front();
          in_valid_i <= 1'b1;
          tx_gap <= draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_kick) begin
      hold_left <= 400;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    rounding_t exp_r;
    int        gap_now;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        transfers_out++;
        if (rounding_queue.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, actual value=%0d err=%0b", $time,
                   rounded_value_o, config_error_o);
        end else begin
          exp_r = rounding_queue.pop_front();
          if (exp_r.err) error_results++;
          if (exp_r.value !== rounded_value_o) begin
            mismatches++;
            $display("%0t: rounded_value expected %0d actual %0d", $time,
                     exp_r.value, rounded_value_o);
          end
          if (exp_r.err !== config_error_o) begin
            mismatches++;
            $display("%0t: config_error expected %0b actual %0b", $time,
                     exp_r.err, config_error_o);
          end
        end
        gap_now = draw_gap();
        if (gap_now > 0) begin
          rx_gap <= gap_now - 1;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= (hold_left > 0 || hold_kick);
        end
      end else if (hold_left > 0 || hold_kick) begin
        out_stall_i <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [DataWidth-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegLodi:     lodi_q = val[0];
      RegRem:      rem_q = val;
      RegDiv:      div_q = val;
      RegMaxScale: max_scale_q = val[MsWidth-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic lodi, logic [30:0] rem, logic [30:0] dv, logic [6:0] ms);
    write_reg(RegLodi, DataWidth'(lodi));
    write_reg(RegRem, rem);
    write_reg(RegDiv, dv);
    write_reg(RegMaxScale, DataWidth'(ms));
  endtask

  function automatic logic signed [31:0] random_coeff();
    longint k;
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 400) - 200;
      1: begin
        k = longint'($urandom_range(0, 40)) - 20;
        return 32'(k * longint'(div_q) + longint'($urandom_range(0, 6)) - 3);
      end
      2: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                     : 32'sh80000000 + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(int count);
    for (int i = 0; i < count; i++) coeff_queue = {coeff_queue, random_coeff()};
    while (coeff_queue.size() > 0 || rounding_queue.size() > 0 || in_valid_i)
      @(posedge clk_i);
    phases_run++;
  endtask

  initial begin
    logic [30:0] dv, rm;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, coefficient extremes
    extreme_coeffs = '{32'sh80000000, 32'sh7fffffff, 32'sd0, -32'sd1, 32'sd1, 32'sd2,
                       -32'sd2, 32'sh40000000, 32'shc0000001, 32'sd60};
    foreach (extreme_coeffs[i]) coeff_queue = {coeff_queue, extreme_coeffs[i]};
    run_phase(0);

    set_config(1'b0, 31'd3, 31'd10, 7'd8);       run_phase(30);
    set_config(1'b1, 31'd3, 31'd10, 7'd8);       run_phase(30);
    set_config(1'b0, 31'd1, 31'h7fffffff, 7'd64); run_phase(30);
    set_config(1'b1, 31'h7ffffffe, 31'h7fffffff, 7'd1); run_phase(30);
    set_config(1'b0, 31'd7, 31'd7, 7'd5);        run_phase(20);
    set_config(1'b0, 31'd0, 31'd0, 7'd3);        run_phase(20);
    set_config(1'b0, 31'd5, 31'd100, 7'd0);      run_phase(30);
    set_config(1'b1, 31'd5, 31'd100, 7'd127);    run_phase(30);
    set_config(1'b0, 31'd1, 31'd3, 7'd64);       run_phase(30);
    set_config(1'b0, 31'd0, 31'd1, 7'd2);        run_phase(30);

    // fill the pipeline behind a long receiver hold-off
    set_config(1'b0, 31'd11, 31'd97, 7'd40);
    burst = 1'b1;
    for (int i = 0; i < 200; i++) coeff_queue = {coeff_queue, random_coeff()};
    @(negedge clk_i) hold_kick = 1'b1;
    @(negedge clk_i) hold_kick = 1'b0;
    run_phase(0);

    for (int p = 0; p < 24; p++) begin
      burst = (p % 4 == 1);
      dv = $urandom_range(0, 1) ? 31'($urandom_range(1, 60)) : 31'($urandom | 1);
      rm = ($urandom_range(0, 9) == 0) ? dv + 31'($urandom_range(0, 2))
                                       : 31'($urandom % dv);
      set_config(1'($urandom_range(0, 1)), rm, dv,
                 ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64)));
      run_phase(50);
    end

    repeat (80) @(posedge clk_i);
    $display("Ran %0d register settings: %0d coefficients in, %0d results out", phases_run,
             transfers_in, transfers_out);
    $display("%0d results flagged a bad remainder", error_results);
    if (mismatches == 0 && rounding_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Timeout with %0d results outstanding", rounding_queue.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/srf_pkg.sv
hw/rtl/srf_cfg.sv
hw/rtl/srf_div.sv
hw/rtl/superadditive_rounding_function.sv
hw/rtl/srf_checker.sv
test/tb_top.sv
